### src/jacobi_eigen_3x3_macros.svh
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver assertion macros
// Shorthand for the clocked, reset-qualified checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef JACOBI_EIGEN_3X3_MACROS_SVH
`define JACOBI_EIGEN_3X3_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled while in reset.
`define JE3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while in reset.
`define JE3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/je3_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver package
// Payload types, widths, CORDIC angle table and the rotation micro-program.
// ----------------------------------------------------------------------------
package je3_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int EPS_SHIFT    = 33;

    localparam int COR_W = 37;   // CORDIC x/y datapath
    localparam int ANG_W = 34;   // binary angle, 2^32 per turn, with headroom
    localparam int OPD_W = 34;   // multiplier data operand
    localparam int ACC_W = 36;   // rounded product and accumulator

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint INV_GAIN    = 64'sd652032874;
    localparam longint HALF_TURN   = 64'sd2147483648;

    localparam logic [0:0] REG_THRESHOLD  = 1'd0;
    localparam logic [0:0] REG_MAX_SWEEPS = 1'd1;

    localparam logic [1:0] IDX_LAST = 2'd2;
    localparam logic [4:0] LAST_STEP = 5'd27;

    // Data operand selects.
    localparam logic [3:0] OP_A  = 4'd0;
    localparam logic [3:0] OP_B  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_EP = 4'd3;
    localparam logic [3:0] OP_EQ = 4'd4;
    localparam logic [3:0] OP_M1 = 4'd5;
    localparam logic [3:0] OP_M2 = 4'd6;
    localparam logic [3:0] OP_N1 = 4'd7;
    localparam logic [3:0] OP_N2 = 4'd8;
    localparam logic [3:0] OP_VP = 4'd9;
    localparam logic [3:0] OP_VQ = 4'd10;

    // Result destinations.
    localparam logic [3:0] DST_ACC  = 4'd0;
    localparam logic [3:0] DST_M1   = 4'd1;
    localparam logic [3:0] DST_M2   = 4'd2;
    localparam logic [3:0] DST_N1   = 4'd3;
    localparam logic [3:0] DST_N2   = 4'd4;
    localparam logic [3:0] DST_HOLD = 4'd5;
    localparam logic [3:0] DST_DIAG = 4'd6;
    localparam logic [3:0] DST_SIDE = 4'd7;
    localparam logic [3:0] DST_VEC  = 4'd8;

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a22;
    } in_t;

    typedef struct packed {
        logic [1:0]         eig_index;
        logic signed [31:0] eig_value;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [7:0]         rotation_count;
        logic               last_pair;
    } out_t;

    typedef struct packed {
        logic       use_s;
        logic [3:0] gsel;
        logic [1:0] row;
        logic       neg;
        logic       first;
        logic [3:0] dst;
    } uop_t;

    typedef struct packed {
        logic [2:0] a_idx;
        logic [2:0] b_idx;
        logic [2:0] d_idx;
        logic [2:0] ep_idx;
        logic [2:0] eq_idx;
        logic [1:0] p;
        logic [1:0] q;
    } pair_map_t;

    // CORDIC command from the sequencer to the CORDIC unit.
    typedef struct packed {
        logic start;
        logic vec_mode;
    } cor_ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                5'd30: v = 32'd1;
                default: v = 32'd0;
            endcase
            atan_at = signed'(ANG_W'(v));
        end
    endfunction

    function automatic pair_map_t pair_map(input logic [1:0] k);
        pair_map_t m;
        begin
            case (k)
                2'd0:    m = '{a_idx: 3'd0, b_idx: 3'd1, d_idx: 3'd3, ep_idx: 3'd2,
                               eq_idx: 3'd4, p: 2'd0, q: 2'd1};
                2'd1:    m = '{a_idx: 3'd0, b_idx: 3'd2, d_idx: 3'd5, ep_idx: 3'd1,
                               eq_idx: 3'd4, p: 2'd0, q: 2'd2};
                default: m = '{a_idx: 3'd3, b_idx: 3'd4, d_idx: 3'd5, ep_idx: 3'd1,
                               eq_idx: 3'd2, p: 2'd1, q: 2'd2};
            endcase
            pair_map = m;
        end
    endfunction

    function automatic logic [2:0] diag_idx(input logic [1:0] k);
        logic [2:0] d;
        begin
            case (k)
                2'd0:    d = 3'd0;
                2'd1:    d = 3'd3;
                default: d = 3'd5;
            endcase
            diag_idx = d;
        end
    endfunction

    function automatic logic [3:0] vidx(input logic [1:0] row, input logic [1:0] col);
        vidx = 4'(row) * 4'd3 + 4'(col);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > ACC_W'(64'sd2147483647)) begin
                r = 32'sh7FFFFFFF;
            end else if (v < -ACC_W'(64'sd2147483648)) begin
                r = 32'sh80000000;
            end else begin
                r = v[31:0];
            end
            sat32 = r;
        end
    endfunction

    // Rotation program: two product terms per stored value.
    function automatic uop_t uop_at(input logic [4:0] step);
        uop_t u;
        logic [4:0] rel;
        begin
            rel = step - 5'd16;
            u = '{use_s: 1'b0, gsel: OP_A, row: 2'd0, neg: 1'b0, first: 1'b1, dst: DST_ACC};
            if (step < 5'd16) begin
                case (step)
                    5'd0:  u = '{1'b0, OP_A,  2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd1:  u = '{1'b1, OP_B,  2'd0, 1'b1, 1'b0, DST_M1};
                    5'd2:  u = '{1'b0, OP_B,  2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd3:  u = '{1'b1, OP_D,  2'd0, 1'b1, 1'b0, DST_M2};
                    5'd4:  u = '{1'b1, OP_A,  2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd5:  u = '{1'b0, OP_B,  2'd0, 1'b0, 1'b0, DST_N1};
                    5'd6:  u = '{1'b1, OP_B,  2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd7:  u = '{1'b0, OP_D,  2'd0, 1'b0, 1'b0, DST_N2};
                    5'd8:  u = '{1'b0, OP_M1, 2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd9:  u = '{1'b1, OP_M2, 2'd0, 1'b1, 1'b0, DST_HOLD};
                    5'd10: u = '{1'b1, OP_N1, 2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd11: u = '{1'b0, OP_N2, 2'd0, 1'b0, 1'b0, DST_DIAG};
                    5'd12: u = '{1'b0, OP_EP, 2'd0, 1'b0, 1'b1, DST_ACC};
                    5'd13: u = '{1'b1, OP_EQ, 2'd0, 1'b1, 1'b0, DST_HOLD};
                    5'd14: u = '{1'b1, OP_EP, 2'd0, 1'b0, 1'b1, DST_ACC};
                    default: u = '{1'b0, OP_EQ, 2'd0, 1'b0, 1'b0, DST_SIDE};
                endcase
            end else begin
                case (rel[1:0])
                    2'd0:    u = '{1'b0, OP_VP, rel[3:2], 1'b0, 1'b1, DST_ACC};
                    2'd1:    u = '{1'b1, OP_VQ, rel[3:2], 1'b1, 1'b0, DST_HOLD};
                    2'd2:    u = '{1'b1, OP_VP, rel[3:2], 1'b0, 1'b1, DST_ACC};
                    default: u = '{1'b0, OP_VQ, rel[3:2], 1'b0, 1'b0, DST_VEC};
                endcase
            end
            uop_at = u;
        end
    endfunction

endpackage

### src/je3_cordic.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver CORDIC unit
// Iterative CORDIC: vectoring gives half of atan2(y, x); rotation gives cos/sin.
// ----------------------------------------------------------------------------
module je3_cordic (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  je3_pkg::cor_ctl_t                  ctl,
    input  logic signed [je3_pkg::COR_W-1:0]   x_in,
    input  logic signed [je3_pkg::COR_W-1:0]   y_in,
    input  logic signed [je3_pkg::ANG_W-1:0]   z_in,
    output logic                               done,
    output logic signed [je3_pkg::ANG_W-1:0]   half_angle,
    output logic signed [31:0]                 cos_out,
    output logic signed [31:0]                 sin_out
);
    import je3_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    localparam logic signed [COR_W-1:0] ONE_C = COR_W'(ONE_Q30);
    localparam logic signed [ANG_W-1:0] HT_A  = ANG_W'(HALF_TURN);

    logic [1:0]               state_reg;
    logic                     done_reg;
    logic                     mode_reg;
    logic [4:0]               i_reg;
    logic signed [COR_W-1:0]  x_reg;
    logic signed [COR_W-1:0]  y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic signed [COR_W-1:0]  xs;
    logic signed [COR_W-1:0]  ys;
    logic signed [ANG_W-1:0]  atn;
    logic                     tiny_xy;

    assign xs      = x_reg >>> i_reg;
    assign ys      = y_reg >>> i_reg;
    assign atn     = atan_at(i_reg);
    assign tiny_xy = (x_reg < ONE_C) && (x_reg > -ONE_C) && (y_reg < ONE_C) && (y_reg > -ONE_C);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (ctl.start) begin
                        mode_reg <= ctl.vec_mode;
                        i_reg    <= 5'd0;
                        if (!ctl.vec_mode) begin
                            // Rotation starts from the gain-compensated unit vector.
                            x_reg     <= COR_W'(INV_GAIN);
                            y_reg     <= '0;
                            z_reg     <= z_in;
                            state_reg <= C_ITER;
                        end else if (y_in == '0) begin
                            // Zero element: angle zero, or a half turn for a negative difference.
                            x_reg    <= x_in;
                            y_reg    <= y_in;
                            z_reg    <= (x_in < 0) ? HT_A : '0;
                            done_reg <= 1'b1;
                        end else begin
                            x_reg     <= x_in;
                            y_reg     <= y_in;
                            z_reg     <= '0;
                            state_reg <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (tiny_xy) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        if (x_reg < 0) begin
                            z_reg <= (y_reg > 0) ? HT_A : -HT_A;
                            x_reg <= -x_reg;
                            y_reg <= -y_reg;
                        end
                        state_reg <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (mode_reg ? (y_reg > 0) : (z_reg < 0)) begin
                        x_reg <= mode_reg ? x_reg + ys : x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= mode_reg ? z_reg + atn : z_reg + atn;
                    end else begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atn;
                    end
                    if (i_reg == 5'(CORDIC_STEPS - 1)) begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        i_reg <= i_reg + 5'd1;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done       = done_reg;
    assign half_angle = z_reg >>> 1;

    always_comb begin
        if (x_reg > ONE_C) begin
            cos_out = 32'(ONE_Q30);
        end else if (x_reg < -ONE_C) begin
            cos_out = -32'(ONE_Q30);
        end else begin
            cos_out = x_reg[31:0];
        end
        if (y_reg > ONE_C) begin
            sin_out = 32'(ONE_Q30);
        end else if (y_reg < -ONE_C) begin
            sin_out = -32'(ONE_Q30);
        end else begin
            sin_out = y_reg[31:0];
        end
    end

endmodule

### src/je3_mulrnd.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver multiply-round unit
// Registered Q2.30 product, rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module je3_mulrnd (
    input  logic                               aclk,
    input  logic                               mul_en,
    input  logic signed [31:0]                 f_in,
    input  logic signed [je3_pkg::OPD_W-1:0]   g_in,
    output logic signed [je3_pkg::ACC_W-1:0]   rnd_out
);
    import je3_pkg::*;

    localparam int PW = OPD_W + 32;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW:0]   p_ext;
    logic signed [PW:0]   r;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= f_in * g_in;
        end
    end

    assign p_ext = (PW+1)'(prod_reg);

    always_comb begin
        if (!prod_reg[PW-1]) begin
            r = (p_ext + (PW+1)'(64'sd536870912)) >>> 30;
        end else begin
            r = -((-p_ext + (PW+1)'(64'sd536870912)) >>> 30);
        end
    end

    assign rnd_out = r[ACC_W-1:0];

endmodule

### src/jacobi_eigen_3x3.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver
// Cyclic Jacobi diagonalization of a symmetric 3x3 matrix in Q16.16.
// ----------------------------------------------------------------------------
// A request carries the six unique entries of a symmetric matrix. The block
// runs cyclic Jacobi sweeps over the pairs (0,1), (0,2), (1,2) until
// max_sweeps sweeps are done or the summed absolute off-diagonals fall to
// convergence_threshold or below, then returns three results, one per
// eigenpair, the last marked by last_pair. Eigenvalues are Q16.16 and
// eigenvectors Q2.30, all saturated. The block takes one request at a time:
// s_ready is high only while it is idle. Each rotation runs the CORDIC atan2
// (normalization shifts, then 24 iterations), the CORDIC sine/cosine and
// the 28 rounded products that one shared multiplier works through; a
// zero or skipped element needs no rotation. Each result waits in an output
// register for m_ready. Registers are written through cfg_we / cfg_index /
// cfg_wdata; the user must do so only while the block is idle, which the
// block itself does not enforce.
`include "jacobi_eigen_3x3_macros.svh"

module jacobi_eigen_3x3 (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  je3_pkg::in_t    s_payload,
    output logic            m_valid,
    input  logic            m_ready,
    output je3_pkg::out_t   m_payload,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [31:0]     cfg_wdata
);
    import je3_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_PAIR  = 4'd3;
    localparam logic [3:0] S_ANG   = 4'd4;
    localparam logic [3:0] S_SC    = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_LOAD  = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;

    localparam int EW = 41;

    // Configuration registers.
    logic [31:0] thr_reg;
    logic [5:0]  max_sweeps_reg;

    // Control state.
    logic [3:0]  state_reg;
    logic [5:0]  sweep_reg;
    logic [7:0]  rot_reg;
    logic [1:0]  pair_reg;
    logic [1:0]  k_reg;
    logic [4:0]  step_reg;
    logic        m_valid_reg;

    // Datapath state.
    logic signed [31:0]      work_reg [6];
    logic signed [31:0]      vec_reg  [9];
    logic [33:0]             err_reg;
    logic signed [31:0]      a_reg, b_reg, d_reg, ep_reg, eq_reg;
    logic signed [31:0]      c_reg, s_reg;
    logic signed [OPD_W-1:0] m1_reg, m2_reg, n1_reg, n2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      hold_reg;
    out_t                    m_payload_reg;

    // Shared units.
    cor_ctl_t                cor_ctl;
    logic signed [COR_W-1:0] cor_x, cor_y;
    logic                    cor_done;
    logic signed [ANG_W-1:0] cor_half;
    logic signed [31:0]      cor_c, cor_s;
    logic                    mul_en;
    logic signed [31:0]      mul_f;
    logic signed [OPD_W-1:0] mul_g;
    logic signed [ACC_W-1:0] mul_rnd;

    pair_map_t               pm;
    uop_t                    uop;
    logic [31:0]             ab, am, dm;
    logic [37:0]             ab45;
    logic                    negl_a, negl_d, skip_early, zero_elem;
    logic signed [ACC_W-1:0] term, sum;
    logic signed [31:0]      sum_sat;
    logic [3:0]              vp_idx, vq_idx;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-33'(v)) : 32'(v);
    endfunction

    assign pm  = pair_map(pair_reg);
    assign uop = uop_at(step_reg);

    // Element tests for the pair under consideration.
    assign ab   = mag32(work_reg[pm.b_idx]);
    assign am   = mag32(work_reg[pm.a_idx]);
    assign dm   = mag32(work_reg[pm.d_idx]);
    assign ab45 = (38'(ab) << 5) + (38'(ab) << 3) + (38'(ab) << 2) + 38'(ab);
    assign negl_a = (am != '0) && (EW'(ab) <= ((EW'(am) - EW'(1)) >> EPS_SHIFT));
    assign negl_d = (dm != '0) && (EW'(ab) <= ((EW'(dm) - EW'(1)) >> EPS_SHIFT));
    assign skip_early = (sweep_reg < 6'd4) && (ab45 < 38'(err_reg));
    assign zero_elem  = (sweep_reg > 6'd3) && negl_a && negl_d;

    // CORDIC command: vectoring on (d - a, 2b) from S_PAIR, rotation on its result.
    always_comb begin
        cor_ctl = '{start: 1'b0, vec_mode: 1'b1};
        if (state_reg == S_PAIR && !skip_early && !zero_elem) begin
            cor_ctl.start = 1'b1;
        end else if (state_reg == S_ANG && cor_done) begin
            cor_ctl = '{start: 1'b1, vec_mode: 1'b0};
        end
    end

    assign cor_x = COR_W'(work_reg[pm.d_idx]) - COR_W'(work_reg[pm.a_idx]);
    assign cor_y = COR_W'(work_reg[pm.b_idx]) <<< 1;

    je3_cordic u_cordic (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (cor_ctl),
        .x_in       (cor_x),
        .y_in       (cor_y),
        .z_in       (cor_half),
        .done       (cor_done),
        .half_angle (cor_half),
        .cos_out    (cor_c),
        .sin_out    (cor_s)
    );

    // Operand selection for the shared multiplier.
    assign vp_idx = vidx(uop.row, pm.p);
    assign vq_idx = vidx(uop.row, pm.q);
    assign mul_en = (state_reg == S_MUL);
    assign mul_f  = uop.use_s ? s_reg : c_reg;

    always_comb begin
        case (uop.gsel)
            OP_A:    mul_g = OPD_W'(a_reg);
            OP_B:    mul_g = OPD_W'(b_reg);
            OP_D:    mul_g = OPD_W'(d_reg);
            OP_EP:   mul_g = OPD_W'(ep_reg);
            OP_EQ:   mul_g = OPD_W'(eq_reg);
            OP_M1:   mul_g = m1_reg;
            OP_M2:   mul_g = m2_reg;
            OP_N1:   mul_g = n1_reg;
            OP_N2:   mul_g = n2_reg;
            OP_VP:   mul_g = OPD_W'(vec_reg[vp_idx]);
            OP_VQ:   mul_g = OPD_W'(vec_reg[vq_idx]);
            default: mul_g = '0;
        endcase
    end

    je3_mulrnd u_mulrnd (
        .aclk    (aclk),
        .mul_en  (mul_en),
        .f_in    (mul_f),
        .g_in    (mul_g),
        .rnd_out (mul_rnd)
    );

    assign term    = uop.neg ? -mul_rnd : mul_rnd;
    assign sum     = (uop.first ? '0 : acc_reg) + term;
    assign sum_sat = sat32(sum);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= 32'd1;
            max_sweeps_reg <= 6'd10;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD:  thr_reg        <= cfg_wdata;
                REG_MAX_SWEEPS: max_sweeps_reg <= cfg_wdata[5:0];
                default:        thr_reg        <= thr_reg;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sweep_reg   <= '0;
            rot_reg     <= '0;
            pair_reg    <= '0;
            k_reg       <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        work_reg[0] <= s_payload.a00;
                        work_reg[1] <= s_payload.a01;
                        work_reg[2] <= s_payload.a02;
                        work_reg[3] <= s_payload.a11;
                        work_reg[4] <= s_payload.a12;
                        work_reg[5] <= s_payload.a22;
                        for (int i = 0; i < 9; i++) begin
                            vec_reg[i] <= (i % 4 == 0) ? 32'(ONE_Q30) : 32'sd0;
                        end
                        sweep_reg <= '0;
                        rot_reg   <= '0;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR: begin
                    err_reg   <= 34'(mag32(work_reg[1])) + 34'(mag32(work_reg[2]))
                               + 34'(mag32(work_reg[4]));
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (sweep_reg < max_sweeps_reg && err_reg > 34'(thr_reg)) begin
                        pair_reg  <= '0;
                        state_reg <= S_PAIR;
                    end else begin
                        k_reg     <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                S_PAIR: begin
                    if (zero_elem) begin
                        // Negligible against both diagonal entries: clear it, no rotation.
                        work_reg[pm.b_idx] <= '0;
                        state_reg          <= S_NEXT;
                    end else if (skip_early) begin
                        state_reg <= S_NEXT;
                    end else begin
                        a_reg     <= work_reg[pm.a_idx];
                        b_reg     <= work_reg[pm.b_idx];
                        d_reg     <= work_reg[pm.d_idx];
                        ep_reg    <= work_reg[pm.ep_idx];
                        eq_reg    <= work_reg[pm.eq_idx];
                        state_reg <= S_ANG;
                    end
                end
                S_ANG: begin
                    if (cor_done) begin
                        state_reg <= S_SC;
                    end
                end
                S_SC: begin
                    if (cor_done) begin
                        c_reg     <= cor_c;
                        s_reg     <= cor_s;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= sum;
                    case (uop.dst)
                        DST_M1:   m1_reg   <= OPD_W'(sum);
                        DST_M2:   m2_reg   <= OPD_W'(sum);
                        DST_N1:   n1_reg   <= OPD_W'(sum);
                        DST_N2:   n2_reg   <= OPD_W'(sum);
                        DST_HOLD: hold_reg <= sum_sat;
                        DST_DIAG: begin
                            work_reg[pm.a_idx] <= hold_reg;
                            work_reg[pm.d_idx] <= sum_sat;
                            work_reg[pm.b_idx] <= '0;
                        end
                        DST_SIDE: begin
                            work_reg[pm.ep_idx] <= hold_reg;
                            work_reg[pm.eq_idx] <= sum_sat;
                        end
                        DST_VEC: begin
                            vec_reg[vp_idx] <= hold_reg;
                            vec_reg[vq_idx] <= sum_sat;
                        end
                        default: ;
                    endcase
                    if (step_reg == LAST_STEP) begin
                        rot_reg   <= rot_reg + 8'd1;
                        state_reg <= S_NEXT;
                    end else begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_NEXT: begin
                    if (pair_reg == 2'd2) begin
                        sweep_reg <= sweep_reg + 6'd1;
                        state_reg <= S_ERR;
                    end else begin
                        pair_reg  <= pair_reg + 2'd1;
                        state_reg <= S_PAIR;
                    end
                end
                S_LOAD: begin
                    m_payload_reg.eig_index      <= k_reg;
                    m_payload_reg.eig_value      <= work_reg[diag_idx(k_reg)];
                    m_payload_reg.vec_x          <= vec_reg[vidx(2'd0, k_reg)];
                    m_payload_reg.vec_y          <= vec_reg[vidx(2'd1, k_reg)];
                    m_payload_reg.vec_z          <= vec_reg[vidx(2'd2, k_reg)];
                    m_payload_reg.rotation_count <= rot_reg;
                    m_payload_reg.last_pair      <= (k_reg == IDX_LAST);
                    m_valid_reg                  <= 1'b1;
                    state_reg                    <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (k_reg == IDX_LAST) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // A new request is never taken while a result is still on offer.
    `JE3_ASSERT_NOW(a_ready_excl, s_ready, !m_valid, "s_ready while a result is pending")
    // In the cycle after a request is taken the block is busy.
    `JE3_ASSERT_NEXT(a_busy_after_req, s_valid && s_ready, !s_ready, "ready right after request")
    // The last-pair mark agrees with the eigenpair index.
    `JE3_ASSERT_NOW(a_last_mark, m_valid,
        m_payload.last_pair == (m_payload.eig_index == IDX_LAST), "last_pair mismatch")
    // Handing over the last eigenpair returns the block to idle.
    `JE3_ASSERT_NEXT(a_idle_after_last, m_valid && m_ready && m_payload.last_pair,
        s_ready && !m_valid, "not idle after last result")

endmodule

### tb/jacobi_eigen_3x3_tb.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver testbench
// Drives symmetric matrices through the solver under several threshold and
// sweep-limit settings and idling patterns, and checks every eigenpair
// against a bit-exact fixed-point Jacobi predictor.
// ----------------------------------------------------------------------------
module jacobi_eigen_3x3_tb;
    import je3_pkg::*;

    localparam int  NUM_RANDOM  = 300;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  SETTLE      = 20000;

    // Rotation angle table, 2^32 per turn.
    localparam longint ARC [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    in_t    s_payload;
    logic   m_valid;
    logic   m_ready;
    out_t   m_payload;
    logic   cfg_we;
    logic   [0:0] cfg_index;
    logic   [31:0] cfg_wdata;

    jacobi_eigen_3x3 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // The predictor keeps its own copy of the two registers.
    longint     stop_level;
    int         sweep_limit;

    out_t       pending_pairs[$];
    int         error_count;
    int         pair_count;
    int         request_count;
    longint     cycle_count;
    int         send_idle_pct;
    int         recv_stall_pct;

    // ------------------------------------------------------------------------
    // Fixed-point helpers of the predictor.
    // ------------------------------------------------------------------------

    // Arithmetic shift right with floor; SystemVerilog >>> already floors.
    function automatic longint shr(longint v, int sh);
        return v >>> sh;
    endfunction

    // Q2.30 product rounding: to nearest, ties away from zero.
    function automatic longint round_q30(longint v);
        return (v >= 0) ? ((v + 64'sd536870912) >>> 30) : -((-v + 64'sd536870912) >>> 30);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Strictly below a * 2^-EPS_SHIFT, tested exactly.
    function automatic bit is_tiny(longint b, longint a);
        return (a != 0) && (b <= ((a - 1) >>> EPS_SHIFT));
    endfunction

    // Half of atan2(y, x) as a binary angle.
    function automatic longint half_atan2(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (y == 0)
            return (x < 0) ? (HALF_TURN >>> 1) : 0;
        while (absval(x) < ONE_Q30 && absval(y) < ONE_Q30) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            z = (y > 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += ARC[i];
            end else begin
                x -= ys; y += xs; z -= ARC[i];
            end
        end
        return shr(z, 1);
    endfunction

    task automatic cos_sin(input longint z, output longint c, output longint s);
        longint x;
        longint y;
        longint xs;
        longint ys;
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr(x, i);
            ys = shr(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARC[i];
            end else begin
                x += ys; y -= xs; z += ARC[i];
            end
        end
        c = (x > ONE_Q30) ? ONE_Q30 : ((x < -ONE_Q30) ? -ONE_Q30 : x);
        s = (y > ONE_Q30) ? ONE_Q30 : ((y < -ONE_Q30) ? -ONE_Q30 : y);
    endtask

    // ------------------------------------------------------------------------
    // Full Jacobi diagonalization of one request; pushes three eigenpairs.
    // Matrix storage: 0=a00 1=a01 2=a02 3=a11 4=a12 5=a22.
    // ------------------------------------------------------------------------
    task automatic diagonalize(input in_t req);
        longint m[6];
        longint v[9];
        longint err;
        longint sweep_err;
        longint a, b, d, ep, eq, c, s, m1, m2, n1, n2, vp, vq;
        int     sweeps;
        int     turns;
        int     pp, qq, ia, ib, id, iep, ieq;
        bit     go;
        out_t   pair;
        m = '{longint'(req.a00), longint'(req.a01), longint'(req.a02),
              longint'(req.a11), longint'(req.a12), longint'(req.a22)};
        for (int i = 0; i < 9; i++)
            v[i] = (i % 4 == 0) ? ONE_Q30 : 0;
        sweeps = 0;
        turns  = 0;
        err = absval(m[1]) + absval(m[2]) + absval(m[4]);
        while (sweeps < sweep_limit && err > stop_level) begin
            sweep_err = err;
            for (int k = 0; k < 3; k++) begin
                case (k)
                    0: begin pp = 0; qq = 1; ia = 0; ib = 1; id = 3; iep = 2; ieq = 4; end
                    1: begin pp = 0; qq = 2; ia = 0; ib = 2; id = 5; iep = 1; ieq = 4; end
                    default: begin pp = 1; qq = 2; ia = 3; ib = 4; id = 5; iep = 1; ieq = 2; end
                endcase
                go = 1'b1;
                if (sweeps < 4 && absval(m[ib]) * 45 < sweep_err)
                    go = 1'b0;
                // Later sweeps drop elements negligible against both diagonals.
                if (sweeps > 3 && is_tiny(absval(m[ib]), absval(m[ia])) &&
                    is_tiny(absval(m[ib]), absval(m[id]))) begin
                    go = 1'b0;
                    m[ib] = 0;
                end
                if (go) begin
                    a = m[ia]; b = m[ib]; d = m[id]; ep = m[iep]; eq = m[ieq];
                    cos_sin(half_atan2(d - a, 2 * b), c, s);
                    m1 = round_q30(c * a) - round_q30(s * b);
                    m2 = round_q30(c * b) - round_q30(s * d);
                    n1 = round_q30(s * a) + round_q30(c * b);
                    n2 = round_q30(s * b) + round_q30(c * d);
                    m[ia]  = clip32(round_q30(c * m1) - round_q30(s * m2));
                    m[id]  = clip32(round_q30(s * n1) + round_q30(c * n2));
                    m[ib]  = 0;
                    m[iep] = clip32(round_q30(c * ep) - round_q30(s * eq));
                    m[ieq] = clip32(round_q30(s * ep) + round_q30(c * eq));
                    for (int r = 0; r < 3; r++) begin
                        vp = v[r * 3 + pp];
                        vq = v[r * 3 + qq];
                        v[r * 3 + pp] = clip32(round_q30(c * vp) - round_q30(s * vq));
                        v[r * 3 + qq] = clip32(round_q30(s * vp) + round_q30(c * vq));
                    end
                    turns++;
                end
            end
            err = absval(m[1]) + absval(m[2]) + absval(m[4]);
            sweeps++;
        end
        for (int k = 0; k < 3; k++) begin
            pair.eig_index      = 2'(k);
            pair.eig_value      = 32'(m[(k == 0) ? 0 : ((k == 1) ? 3 : 5)]);
            pair.vec_x          = 32'(v[k]);
            pair.vec_y          = 32'(v[3 + k]);
            pair.vec_z          = 32'(v[6 + k]);
            pair.rotation_count = 8'(turns);
            pair.last_pair      = (2'(k) == IDX_LAST);
            pending_pairs.push_back(pair);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and cycle limit.
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("[jacobi_eigen_3x3] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, checks at the rising edge.
    // ------------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $error("eigenpair with no request outstanding");
                error_count++;
            end else begin
                want = pending_pairs.pop_front();
                pair_count++;
                if (m_payload.eig_index !== want.eig_index) begin
                    $error("eig_index: expected %0d, got %0d", want.eig_index,
                           m_payload.eig_index);
                    error_count++;
                end
                if (m_payload.eig_value !== want.eig_value) begin
                    $error("eig_value: expected %0d, got %0d", want.eig_value,
                           m_payload.eig_value);
                    error_count++;
                end
                if (m_payload.vec_x !== want.vec_x) begin
                    $error("vec_x: expected %0d, got %0d", want.vec_x, m_payload.vec_x);
                    error_count++;
                end
                if (m_payload.vec_y !== want.vec_y) begin
                    $error("vec_y: expected %0d, got %0d", want.vec_y, m_payload.vec_y);
                    error_count++;
                end
                if (m_payload.vec_z !== want.vec_z) begin
                    $error("vec_z: expected %0d, got %0d", want.vec_z, m_payload.vec_z);
                    error_count++;
                end
                if (m_payload.rotation_count !== want.rotation_count) begin
                    $error("rotation_count: expected %0d, got %0d", want.rotation_count,
                           m_payload.rotation_count);
                    error_count++;
                end
                if (m_payload.last_pair !== want.last_pair) begin
                    $error("last_pair: expected %0d, got %0d", want.last_pair,
                           m_payload.last_pair);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Sends one request, with random idle cycles first, and predicts it.
    // The request is raised only at a later falling edge than the call itself,
    // so it never meets the lowering of the previous one.
    task automatic send_matrix(input in_t req);
        do
            @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct);
        s_valid   <= 1'b1;
        s_payload <= req;
        diagonalize(req);
        do
            @(posedge aclk);
        while (!s_ready);
        request_count++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Waits until every predicted eigenpair is out and the block has settled.
    task automatic drain;
        while (pending_pairs.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Register writes happen only while idle, one cycle each.
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_THRESHOLD)
            stop_level = longint'(value);
        else
            sweep_limit = int'(value[5:0]);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'(int'($urandom_range(32'h00FFFFFF)) - 32'h007FFFFF);
        endcase
    endfunction

    function automatic in_t rand_matrix();
        in_t r;
        r.a00 = rand_entry();
        r.a01 = rand_entry();
        r.a02 = rand_entry();
        r.a11 = rand_entry();
        r.a12 = rand_entry();
        r.a22 = rand_entry();
        // Sometimes leave an off-diagonal at zero to reach the zero-element paths.
        if ($urandom_range(7) == 0)
            r.a01 = 0;
        if ($urandom_range(7) == 0)
            r.a12 = 0;
        return r;
    endfunction

    // Directed table: extremes, zero elements with both signs of the diagonal
    // difference, small operands that need normalizing, and diagonal inputs.
    localparam int NUM_DIRECTED = 16;
    localparam logic [31:0] MAXP = 32'h7FFFFFFF;
    localparam logic [31:0] MAXN = 32'h80000000;

    in_t directed [NUM_DIRECTED] = '{
        '{32'h00010000, 0, 0, 32'h00020000, 0, 32'h00030000},
        '{0, 0, 0, 0, 0, 0},
        '{MAXP, MAXP, MAXP, MAXP, MAXP, MAXP},
        '{MAXN, MAXN, MAXN, MAXN, MAXN, MAXN},
        '{MAXP, MAXN, MAXP, MAXN, MAXN, MAXP},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          32'hFFFFFFFF},
        '{32'h00010000, 32'h00010000, 0, 32'h00010000, 0, 32'h00010000},
        '{32'h00030000, 32'h00010000, 0, 32'h00010000, 0, 0},
        '{32'h00010000, 32'h00010000, 0, 32'h00030000, 0, 0},
        '{0, 32'd1, 32'd1, 0, 32'd1, 0},
        '{32'd3, 32'hFFFFFFFE, 32'd5, 32'd7, 32'hFFFFFFF9, 32'd2},
        '{32'h00020000, 32'h00010000, 32'h00010000, 32'h00020000, 32'h00010000,
          32'h00020000},
        '{32'h40000000, 32'h00000001, 32'h00000001, 32'hC0000000, 32'h00000001,
          32'h20000000},
        '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
          32'hAAAAAAAA},
        '{32'h12345678, 32'h00001234, 32'hFFFF0000, 32'h87654321, 32'h7FFF0000,
          32'h00000000},
        '{MAXN, 32'h00010000, 32'hFFFF0000, MAXP, 32'h00000100, MAXN}
    };

    task automatic check_identity(input in_t req);
        // With no sweep, the diagonal and the identity come straight back.
        out_t want;
        for (int k = 0; k < 3; k++) begin
            want = pending_pairs[pending_pairs.size() - 3 + k];
            if (want.rotation_count != 0 || want.eig_value !==
                ((k == 0) ? req.a00 : ((k == 1) ? req.a11 : req.a22)) ||
                want.vec_x !== ((k == 0) ? 32'sh40000000 : 0)) begin
                $error("eig_value: expected %0d, got %0d (unrotated diagonal)",
                       (k == 0) ? req.a00 : ((k == 1) ? req.a11 : req.a22),
                       want.eig_value);
                error_count++;
            end
        end
    endtask

    initial begin
        int phase;
        error_count    = 0;
        pair_count     = 0;
        request_count  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stop_level     = 1;
        sweep_limit    = 10;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_wdata = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at reset settings.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_matrix(directed[i]);
            // A diagonal input never sweeps, so its answer is known outright.
            if (i == 0)
                check_identity(directed[i]);
        end
        drain();

        // No sweep allowed at all.
        write_reg(REG_MAX_SWEEPS, 32'd0);
        send_matrix(directed[13]);
        check_identity(directed[13]);
        send_matrix(directed[2]);
        check_identity(directed[2]);
        drain();

        // Highest threshold: any input whose off-diagonals sum to 2^32 - 1 or less counts as converged.
        write_reg(REG_MAX_SWEEPS, 32'd63);
        write_reg(REG_THRESHOLD, 32'hFFFFFFFF);
        send_matrix(directed[11]);
        check_identity(directed[11]);
        drain();

        // Random part: four idling phases, each with its own register setting.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            case (phase)
                0: begin write_reg(REG_THRESHOLD, 32'd0);  write_reg(REG_MAX_SWEEPS, 32'd63); end
                1: begin write_reg(REG_THRESHOLD, 32'd1);  write_reg(REG_MAX_SWEEPS, 32'd10); end
                2: begin write_reg(REG_THRESHOLD, $urandom_range(65536));
                         write_reg(REG_MAX_SWEEPS, $urandom_range(1, 8)); end
                default: begin write_reg(REG_THRESHOLD, 32'd100);
                               write_reg(REG_MAX_SWEEPS, 32'd5); end
            endcase
            for (int n = 0; n < NUM_RANDOM / 4; n++) begin
                send_matrix(rand_matrix());
                // Once per phase, hold off until the block has emptied.
                if (n == 20)
                    drain();
            end
            drain();
        end

        while (pending_pairs.size() != 0)
            @(negedge aclk);
        repeat (SETTLE / 100) @(negedge aclk);

        $display("Ran %0d matrices, %0d eigenpairs checked, four idling patterns,",
                 request_count, pair_count);
        $display("thresholds 0 to max and sweep limits 0 to 63.");
        if (error_count == 0)
            $display("[jacobi_eigen_3x3] OK");
        else
            $display("[jacobi_eigen_3x3] ERROR");
        $finish;
    end

endmodule

### jacobi_eigen_3x3.f
+incdir+src
src/je3_pkg.sv
src/je3_cordic.sv
src/je3_mulrnd.sv
src/jacobi_eigen_3x3.sv
tb/jacobi_eigen_3x3_tb.sv
